[hdl/lsph_pkg.sv]
`timescale 1ns / 1ps

package lsph_pkg;

	// Remainder unit sizing: the widest dividend is hash + term * power (24 bits),
	// padded to 26 bits; the unit retires two bits per cycle.
	localparam int DIVIDEND_W = 26;
	localparam int DIVISOR_W  = 13;
	localparam int STEP_W     = 4;

	localparam int LETTER_W   = 5;
	localparam int HASH_W     = 12;
	localparam int TERM_W     = 12;
	localparam int CFG_W      = 13;
	localparam int INDEX_W    = 2;
	localparam int MOD_W      = 9;

	localparam logic [INDEX_W-1:0] REG_TABLE_SIZE     = 2'd0;
	localparam logic [INDEX_W-1:0] REG_FIRST_MODULUS  = 2'd1;
	localparam logic [INDEX_W-1:0] REG_SECOND_MODULUS = 2'd2;

	localparam logic [CFG_W-1:0] TABLE_LIMIT = 13'd4096;
	localparam logic [5:0]       POWER_BASE  = 6'd53;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_A,
		ST_MOD_B,
		ST_TERM,
		ST_PROD,
		ST_MOD_H,
		ST_MOD_P,
		ST_MOD_F
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
		logic [STEP_W-1:0]     steps;
	} rem_req_t;

endpackage

[hdl/lsph_rem.sv]
`timescale 1ns / 1ps

module lsph_rem import lsph_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rem_req_t             req,
	output logic                 busy,
	output logic [DIVISOR_W-1:0] remainder
);

	logic [DIVIDEND_W-1:0] dividend_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [STEP_W-1:0]     count_q;
	logic                  busy_q;

	logic [DIVISOR_W:0]   r1, r2, dext;
	logic [DIVISOR_W-1:0] r1_red, r2_red;

	// Restoring remainder, two dividend bits per cycle. The dividend is
	// consumed from its top bit, so callers place the value at the top.
	always_comb begin
		dext   = {1'b0, divisor_q};
		r1     = {rem_q, dividend_q[DIVIDEND_W-1]};
		r1_red = (r1 >= dext) ? DIVISOR_W'(r1 - dext) : r1[DIVISOR_W-1:0];
		r2     = {r1_red, dividend_q[DIVIDEND_W-2]};
		r2_red = (r2 >= dext) ? DIVISOR_W'(r2 - dext) : r2[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			count_q <= req.steps;
		end else if (busy_q) begin
			count_q <= count_q - STEP_W'(1);
			if (count_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[DIVIDEND_W-3:0], 2'b00};
			rem_q      <= r2_red;
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("remainder unit did not start");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && count_q == STEP_W'(1) && !req.start) |=> !busy_q)
		else $error("remainder unit ran past its step count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < divisor_q))
		else $error("partial remainder not below divisor");

endmodule

[hdl/lowercase_string_poly_hash.sv]
`timescale 1ns / 1ps

// Polynomial hash of a lowercase name streamed one letter per transfer; the
// transfer that carries last produces one result with the hash reduced below
// table_size and a flag for names longer than MAX_LEN letters. Every modulo
// runs on a single shared remainder unit that retires two dividend bits per
// cycle. Letters past MAX_LEN are accepted without being hashed, and a final
// one still ends the name and produces the result.
// The input is not ready while a letter is being worked on. A finished hash
// sits in an output register, so the next name can start while it waits.
// Configuration may be written between letters and applies to the next one.

module lowercase_string_poly_hash import lsph_pkg::*; #(
	parameter int MAX_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [LETTER_W-1:0] letter,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [HASH_W-1:0]   hash_value,
	output logic                too_long
);

	localparam int PosW = $clog2(MAX_LEN + 1);
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);

	localparam logic [STEP_W-1:0] StepsLetter = 4'd3;
	localparam logic [STEP_W-1:0] StepsProd   = 4'd12;
	localparam logic [STEP_W-1:0] StepsPower  = 4'd9;
	localparam logic [STEP_W-1:0] StepsHash   = 4'd6;

	state_t state_q, state_d;

	logic [CFG_W-1:0] table_size_q;
	logic [MOD_W-1:0] first_modulus_q, second_modulus_q;

	logic [HASH_W-1:0]   hash_q, power_q;
	logic [PosW-1:0]     pos_q;
	logic                overflow_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic [LETTER_W-1:0] ra_q, rb_q;
	logic [TERM_W-1:0]   term_q;

	logic                out_valid_q;
	logic [HASH_W-1:0]   hash_value_q;
	logic                too_long_q;

	logic [CFG_W-1:0]    m_eff;
	logic [MOD_W-1:0]    a_eff, b_eff;
	logic                full;
	logic                accept;
	logic                out_free;

	rem_req_t             rem_req;
	logic                 rem_busy;
	logic [DIVISOR_W-1:0] rem_val;

	logic load_letter, load_ra, load_rb, load_term, load_hash, load_power;
	logic mark_overflow, load_out;

	logic [23:0] prod;
	logic [17:0] power_next;

	lsph_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (rem_req),
		.busy      (rem_busy),
		.remainder (rem_val)
	);

	// A zero modulus behaves as one; the table never exceeds 4096 entries.
	always_comb begin
		if (table_size_q == '0) begin
			m_eff = CFG_W'(1);
		end else if (table_size_q > TABLE_LIMIT) begin
			m_eff = TABLE_LIMIT;
		end else begin
			m_eff = table_size_q;
		end
		a_eff = (first_modulus_q == '0) ? MOD_W'(1) : first_modulus_q;
		b_eff = (second_modulus_q == '0) ? MOD_W'(1) : second_modulus_q;
	end

	assign full       = (pos_q >= MaxPos);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign prod       = 24'(term_q) * 24'(power_q) + 24'(hash_q);
	assign power_next = 18'(power_q) * 18'(POWER_BASE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!full) begin
						state_d = ST_MOD_A;
					end else if (last) begin
						state_d = ST_MOD_F;
					end
				end
			end
			ST_MOD_A: if (!rem_busy) state_d = ST_MOD_B;
			ST_MOD_B: if (!rem_busy) state_d = ST_TERM;
			ST_TERM:  state_d = ST_PROD;
			ST_PROD:  state_d = ST_MOD_H;
			ST_MOD_H: if (!rem_busy) state_d = ST_MOD_P;
			ST_MOD_P: begin
				if (!rem_busy) begin
					state_d = last_q ? ST_MOD_F : ST_IDLE;
				end
			end
			ST_MOD_F: if (!rem_busy && out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		rem_req       = '0;
		load_letter   = 1'b0;
		load_ra       = 1'b0;
		load_rb       = 1'b0;
		load_term     = 1'b0;
		load_hash     = 1'b0;
		load_power    = 1'b0;
		mark_overflow = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				load_letter = in_valid;
				if (in_valid && !full) begin
					rem_req.start    = 1'b1;
					rem_req.dividend = {1'b0, letter, 20'b0};
					rem_req.divisor  = DIVISOR_W'(a_eff);
					rem_req.steps    = StepsLetter;
				end else if (in_valid) begin
					mark_overflow = 1'b1;
					if (last) begin
						rem_req.start    = 1'b1;
						rem_req.dividend = {hash_q, 14'b0};
						rem_req.divisor  = m_eff;
						rem_req.steps    = StepsHash;
					end
				end
			end
			ST_MOD_A: begin
				if (!rem_busy) begin
					load_ra          = 1'b1;
					rem_req.start    = 1'b1;
					rem_req.dividend = {1'b0, letter_q, 20'b0};
					rem_req.divisor  = DIVISOR_W'(b_eff);
					rem_req.steps    = StepsLetter;
				end
			end
			ST_MOD_B: load_rb = !rem_busy;
			ST_TERM:  load_term = 1'b1;
			ST_PROD: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = {prod, 2'b0};
				rem_req.divisor  = m_eff;
				rem_req.steps    = StepsProd;
			end
			ST_MOD_H: begin
				if (!rem_busy) begin
					load_hash        = 1'b1;
					rem_req.start    = 1'b1;
					rem_req.dividend = {power_next, 8'b0};
					rem_req.divisor  = m_eff;
					rem_req.steps    = StepsPower;
				end
			end
			ST_MOD_P: begin
				if (!rem_busy) begin
					load_power = 1'b1;
					if (last_q) begin
						rem_req.start    = 1'b1;
						rem_req.dividend = {hash_q, 14'b0};
						rem_req.divisor  = m_eff;
						rem_req.steps    = StepsHash;
					end
				end
			end
			ST_MOD_F: load_out = !rem_busy && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			table_size_q     <= CFG_W'(1);
			first_modulus_q  <= MOD_W'(2);
			second_modulus_q <= MOD_W'(3);
			hash_q           <= '0;
			power_q          <= HASH_W'(1);
			pos_q            <= '0;
			overflow_q       <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TABLE_SIZE:     table_size_q     <= cfg_data;
					REG_FIRST_MODULUS:  first_modulus_q  <= cfg_data[MOD_W-1:0];
					REG_SECOND_MODULUS: second_modulus_q <= cfg_data[MOD_W-1:0];
					default: ;
				endcase
			end
			if (mark_overflow) begin
				overflow_q <= 1'b1;
			end
			if (load_hash) begin
				hash_q <= rem_val[HASH_W-1:0];
			end
			if (load_power) begin
				power_q <= rem_val[HASH_W-1:0];
				pos_q   <= pos_q + PosW'(1);
			end
			if (load_out) begin
				// The name is complete: start the next one from a clean state.
				hash_q      <= '0;
				power_q     <= HASH_W'(1);
				pos_q       <= '0;
				overflow_q  <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_letter) begin
			letter_q <= letter;
			last_q   <= last;
		end
		if (load_ra) begin
			ra_q <= rem_val[LETTER_W-1:0];
		end
		if (load_rb) begin
			rb_q <= rem_val[LETTER_W-1:0];
		end
		if (load_term) begin
			term_q <= TERM_W'(ra_q) + TERM_W'(pos_q) * TERM_W'(rb_q);
		end
		if (load_out) begin
			hash_value_q <= rem_val[HASH_W-1:0];
			too_long_q   <= overflow_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;
	assign too_long   = too_long_q;

	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rem_busy)
		else $error("input ready while the remainder unit is busy");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MaxPos)
		else $error("letter position beyond the length limit");

	a_overflow_set: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |=> overflow_q)
		else $error("overlong name did not raise the overflow flag");

	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (13'(hash_value_q) < $past(m_eff)))
		else $error("hash not reduced below the table size");

endmodule
